// File: rtl/core/prf_pkg.sv
// Shared types and constants of the page replacement engine.
package prf_pkg;

  // Input item kinds.
  localparam logic KIND_REF   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Replacement policies.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Configuration register indexes.
  localparam int  REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAMES = 1'b1;

  // Fixed field widths.
  localparam int FRAMES_W    = 5;
  localparam int PAGE_IN_W   = 16;
  localparam int FRAME_OUT_W = 4;
  localparam int EVICT_W     = 16;
  localparam int COUNT_W     = 16;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch an accepted input transaction
    logic decide;   // register the hit search and victim choice
    logic commit;   // update frames and load the result register
  } prf_cmd_t;

endpackage

// File: rtl/core/prf_ctrl.sv
// Controller state machine of the page replacement engine.
module prf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output prf_pkg::prf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   in_fire;

  // The result register can take a new result when it is empty or being drained.
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_COMMIT) && slot_free);
  assign in_fire   = in_tvalid && in_tready;

  assign cmd.capture = in_fire;
  assign cmd.decide  = (state_r == S_DECIDE);
  assign cmd.commit  = (state_r == S_COMMIT) && slot_free;

  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) state_nxt = in_fire ? S_DECIDE : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/prf_dpath.sv
// Datapath of the page replacement engine: frame table, recency ranks and result register.
module prf_dpath #(
  parameter int FRAME_COUNT = 16,
  parameter int PAGE_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  prf_pkg::prf_cmd_t                    cmd,
  input  logic                                 policy_mode,
  input  logic [prf_pkg::FRAMES_W-1:0]         frames_in_use,
  input  logic                                 in_kind,
  input  logic [prf_pkg::PAGE_IN_W-1:0]        in_page,
  output logic                                 res_hit,
  output logic [prf_pkg::FRAME_OUT_W-1:0]      res_frame_index,
  output logic                                 res_evicted_valid,
  output logic [prf_pkg::EVICT_W-1:0]          res_evicted_page,
  output logic [prf_pkg::COUNT_W-1:0]          res_fault_count
);

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam int CNT_W = $clog2(FRAME_COUNT + 1);

  // Frame table and recency state.
  logic [PAGE_BITS-1:0]         frame_page_r [FRAME_COUNT];
  logic [IDX_W-1:0]             rank_r       [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]       valid_r;
  logic [IDX_W-1:0]             ptr_r;
  logic [prf_pkg::COUNT_W-1:0]  faults_r;

  // Captured input transaction.
  logic                         kind_r;
  logic [PAGE_BITS-1:0]         page_r;

  // Decision registered between the search cycle and the update cycle.
  logic                         d_hit_r;
  logic [IDX_W-1:0]             d_slot_r;
  logic                         d_was_valid_r;
  logic [PAGE_BITS-1:0]         d_ev_page_r;
  logic [IDX_W-1:0]             d_old_rank_r;
  logic [IDX_W-1:0]             d_ptr_nxt_r;

  // Search logic.
  logic [CNT_W-1:0]             n_act;
  logic                         hit_found;
  logic [IDX_W-1:0]             hit_idx;
  logic                         empty_found;
  logic [IDX_W-1:0]             empty_idx;
  logic [IDX_W-1:0]             lru_idx;
  logic [IDX_W-1:0]             ptr_eff;
  logic [IDX_W-1:0]             ptr_nxt;
  logic [IDX_W-1:0]             slot;
  logic [IDX_W-1:0]             t_rank [FRAME_COUNT];
  logic [IDX_W-1:0]             t_idx  [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]       t_ok;

  logic [prf_pkg::COUNT_W-1:0]  faults_nxt;
  logic                         is_clear;
  logic                         ev_valid;

  always_comb begin
    if (frames_in_use == '0) n_act = CNT_W'(1);
    else if (int'(frames_in_use) > FRAME_COUNT) n_act = CNT_W'(FRAME_COUNT);
    else n_act = CNT_W'(frames_in_use);
  end

  // Lowest active frame holding the page, and lowest active empty frame.
  always_comb begin
    hit_found   = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (i < int'(n_act)) begin
        if (valid_r[i] && (frame_page_r[i] == page_r)) begin
          hit_found = 1'b1;
          hit_idx   = IDX_W'(i);
        end
        if (!valid_r[i]) begin
          empty_found = 1'b1;
          empty_idx   = IDX_W'(i);
        end
      end
    end
  end

  // Oldest active frame by a comparison tree; ties keep the lower index.
  always_comb begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      t_rank[i] = rank_r[i];
      t_idx[i]  = IDX_W'(i);
      t_ok[i]   = (i < int'(n_act));
    end
    for (int s = 1; s < FRAME_COUNT; s = s * 2) begin
      for (int i = 0; i + s < FRAME_COUNT; i = i + 2 * s) begin
        if (t_ok[i + s] && (!t_ok[i] || (t_rank[i + s] > t_rank[i]))) begin
          t_rank[i] = t_rank[i + s];
          t_idx[i]  = t_idx[i + s];
          t_ok[i]   = 1'b1;
        end
      end
    end
    lru_idx = t_idx[0];
  end

  // The round-robin pointer wraps to frame 0 when the frame count has shrunk below it.
  always_comb begin
    ptr_eff = (int'(ptr_r) >= int'(n_act)) ? '0 : ptr_r;
    ptr_nxt = ((int'(ptr_eff) + 1) >= int'(n_act)) ? '0 : ptr_eff + IDX_W'(1);
  end

  always_comb begin
    if (hit_found) slot = hit_idx;
    else if (policy_mode == prf_pkg::POLICY_FIFO) slot = ptr_eff;
    else if (empty_found) slot = empty_idx;
    else slot = lru_idx;
  end

  assign is_clear = (kind_r == prf_pkg::KIND_CLEAR);
  assign ev_valid = !d_hit_r && d_was_valid_r;

  always_comb begin
    if (d_hit_r || (faults_r == prf_pkg::COUNT_MAX)) faults_nxt = faults_r;
    else faults_nxt = faults_r + prf_pkg::COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      page_r <= PAGE_BITS'(in_page);
    end
    if (cmd.decide) begin
      d_hit_r       <= hit_found;
      d_slot_r      <= slot;
      d_was_valid_r <= valid_r[slot];
      d_ev_page_r   <= frame_page_r[slot];
      d_old_rank_r  <= rank_r[slot];
      d_ptr_nxt_r   <= ptr_nxt;
    end
    if (cmd.commit) begin
      if (is_clear) begin
        res_hit           <= 1'b0;
        res_frame_index   <= '0;
        res_evicted_valid <= 1'b0;
        res_evicted_page  <= '0;
        res_fault_count   <= '0;
      end else begin
        // Move the chosen frame to the front and age the frames that were newer.
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (IDX_W'(i) == d_slot_r) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (!d_was_valid_r || (rank_r[i] < d_old_rank_r))) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
        if (!d_hit_r) frame_page_r[d_slot_r] <= page_r;
        res_hit           <= d_hit_r;
        res_frame_index   <= prf_pkg::FRAME_OUT_W'(d_slot_r);
        res_evicted_valid <= ev_valid;
        res_evicted_page  <= ev_valid ? prf_pkg::EVICT_W'(d_ev_page_r) : '0;
        res_fault_count   <= faults_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      ptr_r    <= '0;
      faults_r <= '0;
    end else if (cmd.commit) begin
      if (is_clear) begin
        valid_r  <= '0;
        ptr_r    <= '0;
        faults_r <= '0;
      end else begin
        faults_r <= faults_nxt;
        if (!d_hit_r) begin
          valid_r[d_slot_r] <= 1'b1;
          if (policy_mode == prf_pkg::POLICY_FIFO) ptr_r <= d_ptr_nxt_r;
        end
      end
    end
  end

endmodule

// File: rtl/core/page_replacement_fifo_lru_top.sv
// Top level of the page replacement engine: stream ports, register port and core wiring.
//
// Each input transaction names a page (or clears all frames) and yields exactly one result
// transaction: hit flag, frame index, displaced page and the saturating fault count. Each
// transaction is processed in order: a decide state searches the active frames in parallel
// and chooses the victim (lowest empty frame or oldest frame in LRU mode, round-robin
// pointer in FIFO mode), then a commit state updates the frame table, the recency ranks
// and the pointer and loads the result register. The next input is taken in the cycle
// the result is loaded as long as the result register is free or being drained.
// Registers are at byte 0 (policy: 0 FIFO, 1 LRU) and byte 4 (frames in use, 0 treated
// as 1, above the frame count saturated); write them only while the engine is idle.
module page_replacement_fifo_lru_top #(
  parameter int FRAME_COUNT = 16,
  parameter int PAGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] page_number
  input  logic        in_tuser,   // [0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] hit, [4:1] frame_index, [5] evicted_valid,
                                  // [21:6] evicted_page, [37:22] fault_count, [39:38] zero
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                                  policy_r;
  logic [prf_pkg::FRAMES_W-1:0]          frames_r;
  logic [prf_pkg::REG_IDX_W-1:0]         reg_idx;
  logic                                  cfg_wr;
  prf_pkg::prf_cmd_t                     cmd;

  logic                                  res_hit;
  logic [prf_pkg::FRAME_OUT_W-1:0]       res_frame_index;
  logic                                  res_evicted_valid;
  logic [prf_pkg::EVICT_W-1:0]           res_evicted_page;
  logic [prf_pkg::COUNT_W-1:0]           res_fault_count;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= prf_pkg::POLICY_FIFO;
      frames_r <= prf_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        prf_pkg::REG_POLICY: policy_r <= cfg_pwdata[0];
        prf_pkg::REG_FRAMES: frames_r <= cfg_pwdata[prf_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      prf_pkg::REG_POLICY: cfg_prdata = {31'd0, policy_r};
      prf_pkg::REG_FRAMES: cfg_prdata = {{(32 - prf_pkg::FRAMES_W){1'b0}}, frames_r};
      default:             cfg_prdata = '0;
    endcase
  end

  prf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  prf_dpath #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .policy_mode       (policy_r),
    .frames_in_use     (frames_r),
    .in_kind           (in_tuser),
    .in_page           (in_tdata),
    .res_hit           (res_hit),
    .res_frame_index   (res_frame_index),
    .res_evicted_valid (res_evicted_valid),
    .res_evicted_page  (res_evicted_page),
    .res_fault_count   (res_fault_count)
  );

  assign out_tdata = {2'b00, res_fault_count, res_evicted_page, res_evicted_valid,
                      res_frame_index, res_hit};

endmodule

// File: bench/page_replacement_fifo_lru_top_tb.sv
// Self-checking testbench for the FIFO/LRU page replacement engine.
module page_replacement_fifo_lru_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES  = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 6;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame_index;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [15:0] fault_count;
  } page_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] page_number
  logic        in_tuser;   // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [0] hit, [4:1] frame_index, [5] evicted_valid,
                           // [21:6] evicted_page, [37:22] fault_count, [39:38] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  page_replacement_fifo_lru_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow copy of the engine's registers and frame table.
  logic                          policy_reg;
  logic [prf_pkg::FRAMES_W-1:0]  frames_reg;
  logic [15:0]                   shadow_page [NUM_FRAMES];
  logic                          shadow_valid [NUM_FRAMES];
  logic [3:0]                    shadow_rank [NUM_FRAMES];
  logic [3:0]                    shadow_ptr;
  logic [prf_pkg::COUNT_W-1:0]   shadow_faults;

  page_result_t pending_results[$];
  int           fail_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic [15:0]  page_base;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void clear_frames();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      shadow_page[i]  = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = '0;
    end
    shadow_ptr    = '0;
    shadow_faults = '0;
  endfunction

  function automatic int active_frames();
    if (frames_reg == 0) return 1;
    if (frames_reg > NUM_FRAMES) return NUM_FRAMES;
    return int'(frames_reg);
  endfunction

  // Move frame f to the front of the recency order.
  function automatic void promote_frame(int f, logic was_valid);
    logic [3:0] old_rank;
    old_rank = shadow_rank[f];
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (i != f && shadow_valid[i] && (!was_valid || shadow_rank[i] < old_rank))
        shadow_rank[i] = shadow_rank[i] + 4'd1;
    end
    shadow_rank[f] = '0;
  endfunction

  function automatic page_result_t replace_page(logic kind, logic [15:0] page);
    page_result_t r;
    int           n;
    int           slot;
    logic         found;
    logic         empty_found;
    logic         was_valid;
    r = '0;
    if (kind == prf_pkg::KIND_CLEAR) begin
      clear_frames();
      return r;
    end
    n = active_frames();
    slot = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      promote_frame(slot, 1'b1);
    end else begin
      if (policy_reg == prf_pkg::POLICY_FIFO) begin
        if (shadow_ptr >= n) shadow_ptr = '0;
        slot = shadow_ptr;
        shadow_ptr = (shadow_ptr + 1 >= n) ? 4'd0 : shadow_ptr + 4'd1;
      end else begin
        empty_found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!empty_found && !shadow_valid[i]) begin
            slot = i;
            empty_found = 1'b1;
          end
        end
        if (!empty_found) begin
          slot = 0;
          for (int i = 1; i < n; i++)
            if (shadow_rank[i] > shadow_rank[slot]) slot = i;
        end
      end
      was_valid = shadow_valid[slot];
      if (was_valid) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = shadow_page[slot];
      end
      promote_frame(slot, was_valid);
      shadow_page[slot]  = page;
      shadow_valid[slot] = 1'b1;
      if (shadow_faults != prf_pkg::COUNT_MAX) shadow_faults = shadow_faults + 1'b1;
    end
    r.hit         = found;
    r.frame_index = slot[3:0];
    r.fault_count = shadow_faults;
    return r;
  endfunction

  task automatic report_failure(string what, page_result_t exp_r, page_result_t act_r);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] %s: expected hit=%0b frame=%0d ev=%0b ev_page=%h faults=%0d, ",
               $realtime, what, exp_r.hit, exp_r.frame_index, exp_r.evicted_valid,
               exp_r.evicted_page, exp_r.fault_count,
               "got hit=%0b frame=%0d ev=%0b ev_page=%h faults=%0d",
               act_r.hit, act_r.frame_index, act_r.evicted_valid, act_r.evicted_page,
               act_r.fault_count);
    fail_count++;
  endtask

  // Result checker: each result transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    page_result_t act_r;
    page_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r.hit           = out_tdata[0];
      act_r.frame_index   = out_tdata[4:1];
      act_r.evicted_valid = out_tdata[5];
      act_r.evicted_page  = out_tdata[21:6];
      act_r.fault_count   = out_tdata[37:22];
      if (pending_results.size() == 0) begin
        report_failure("unexpected result", '0, act_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (act_r != exp_r || out_tdata[39:38] != 2'b00)
          report_failure("result mismatch", exp_r, act_r);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic kind, logic [15:0] page);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = page;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(replace_page(kind, page));
    @(negedge clk);
  endtask

  task automatic send_ref(logic [15:0] page);
    send_item(prf_pkg::KIND_REF, page);
  endtask

  task automatic send_clear(logic [15:0] page);
    send_item(prf_pkg::KIND_CLEAR, page);
  endtask

  // Let every result drain, plus the pipeline latency, before touching registers.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [prf_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
    wait_idle();
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == prf_pkg::REG_POLICY) policy_reg = value[0];
    else frames_reg = value[prf_pkg::FRAMES_W-1:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic test_fifo_basics();
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    send_ref(16'h0000);
    send_clear(16'hFFFF);
    write_reg(prf_pkg::REG_FRAMES, 32'd2);
    send_ref(16'h0001);
    send_ref(16'h0002);
    send_ref(16'h0003);
    send_ref(16'h0002);
  endtask

  task automatic test_lru_policy();
    write_reg(prf_pkg::REG_POLICY, {31'h0, prf_pkg::POLICY_LRU});
    send_clear(16'h0000);
    send_ref(16'hA5A5);
    send_ref(16'h5A5A);
    send_ref(16'hA5A5);
    send_ref(16'h1234);
    send_ref(16'h5A5A);
  endtask

  // Zero and oversized frame counts, pointer wrap after shrinking, and a
  // page duplicated across frames once the window grows again.
  task automatic test_frame_limits();
    write_reg(prf_pkg::REG_POLICY, {31'h0, prf_pkg::POLICY_FIFO});
    write_reg(prf_pkg::REG_FRAMES, 32'd16);
    send_clear(16'h0000);
    send_ref(16'h0010);
    send_ref(16'h0011);
    send_ref(16'h0012);
    write_reg(prf_pkg::REG_FRAMES, 32'd0);
    send_ref(16'h0013);
    send_ref(16'h0011);
    write_reg(prf_pkg::REG_FRAMES, 32'hFFFF_FFFF);
    send_ref(16'h0011);
    send_ref(16'h0014);
  endtask

  function automatic logic [prf_pkg::FRAMES_W-1:0] pick_frames();
    unique case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd2;
      3: return 5'd16;
      4: return 5'd31;
      5: return 5'd17;
      default: return 5'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic random_segment(int count);
    logic [31:0] upper;
    int          roll;
    upper = $urandom();
    write_reg(prf_pkg::REG_POLICY, {upper[31:1], 1'($urandom_range(0, 1))});
    upper = $urandom();
    write_reg(prf_pkg::REG_FRAMES, {upper[31:prf_pkg::FRAMES_W], pick_frames()});
    page_base = 16'($urandom());
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)
        send_clear(16'($urandom()));
      else if (roll < 10)
        send_ref(16'($urandom()));
      else
        send_ref(page_base + 16'($urandom_range(0, active_frames() + 2)));
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct  = 27;
          recv_stall_pct = 71;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 27;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 6; seg++) random_segment(70);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = prf_pkg::KIND_REF;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    send_idle_pct  = 27;
    recv_stall_pct = 71;
    page_base      = '0;
    policy_reg     = prf_pkg::POLICY_FIFO;
    frames_reg     = prf_pkg::FRAMES_RESET;
    clear_frames();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_fifo_basics();
    test_lru_policy();
    test_frame_limits();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
